FILE: rtl/gn3_pkg.sv
// ----------------------------------------------------------------------------
// gn3_pkg
// Shared constants, the permutation ROM and the gradient and interpolation
// helpers of the 3-D gradient noise pipeline.
// ----------------------------------------------------------------------------
package gn3_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int CELL_BITS = 8;
  localparam int OUT_BITS  = 19;

  // Fade weight: unsigned, at most one.
  localparam int FADE_W = FRAC_BITS + 1;
  // Corner offset: signed, from minus one up to just below one.
  localparam int OFS_W  = FRAC_BITS + 2;
  // Gradient dot product: sum of two offsets.
  localparam int GRAD_W = FRAC_BITS + 3;
  // Interpolated values, with headroom for truncation.
  localparam int LERP_W = FRAC_BITS + 5;

  localparam logic [CELL_BITS-1:0] PERM_ROM [256] = '{
    8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
    8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
    8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
    8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
    8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
    8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
    8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
    8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
    8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
    8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
    8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
    8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
    8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
    8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
    8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
    8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
    8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
    8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
    8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
    8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
    8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
    8'd215,8'd61,8'd156,8'd180
  };

  localparam logic [3:0] H_SEL_X0 = 4'd12;
  localparam logic [3:0] H_SEL_X1 = 4'd14;

  // Dot product of one of 12 gradient directions with a corner offset.
  function automatic logic signed [GRAD_W-1:0] grad_dot(
    input logic [3:0]               h,
    input logic signed [OFS_W-1:0]  x,
    input logic signed [OFS_W-1:0]  y,
    input logic signed [OFS_W-1:0]  z
  );
    logic signed [GRAD_W-1:0] gu;
    logic signed [GRAD_W-1:0] gv;
    gu = (h < 4'd8) ? GRAD_W'(x) : GRAD_W'(y);
    if (h < 4'd4) begin
      gv = GRAD_W'(y);
    end else if (h == H_SEL_X0 || h == H_SEL_X1) begin
      gv = GRAD_W'(x);
    end else begin
      gv = GRAD_W'(z);
    end
    if (h[0]) gu = -gu;
    if (h[1]) gv = -gv;
    return gu + gv;
  endfunction

  // a + t * (b - a), the product truncated toward minus infinity.
  function automatic logic signed [LERP_W-1:0] lerp(
    input logic [FADE_W-1:0]         t,
    input logic signed [LERP_W-1:0]  a,
    input logic signed [LERP_W-1:0]  b
  );
    logic signed [LERP_W:0]                 diff;
    logic signed [FADE_W+LERP_W+1:0]        prod;
    diff = (LERP_W+1)'(b) - (LERP_W+1)'(a);
    prod = (FADE_W+LERP_W+2)'(signed'({1'b0, t})) * (FADE_W+LERP_W+2)'(diff);
    return a + LERP_W'(prod >>> FRAC_BITS);
  endfunction

endpackage

FILE: rtl/gn3_if.sv
// ----------------------------------------------------------------------------
// gn3_in_if / gn3_out_if
// Valid/ready channels for coordinates in and noise values out.
// ----------------------------------------------------------------------------
interface gn3_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [gn3_pkg::COORD_W-1:0]     coord_x;
  logic signed [gn3_pkg::COORD_W-1:0]     coord_y;
  logic signed [gn3_pkg::COORD_W-1:0]     coord_z;

  modport source (output valid, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface gn3_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [gn3_pkg::OUT_BITS-1:0]    noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

FILE: rtl/gn3_fade.sv
// ----------------------------------------------------------------------------
// gn3_fade
// Three-stage quintic fade curve s(f) = f^3 * (f * (6f - 15) + 10).
// ----------------------------------------------------------------------------
module gn3_fade (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [gn3_pkg::FRAC_BITS-1:0]      frac_i,
  output logic [gn3_pkg::FADE_W-1:0]         fade_o
);
  localparam int F  = gn3_pkg::FRAC_BITS;
  localparam int MW = F + 6;
  localparam int PW = 2 * F + 7;

  logic [F-1:0]          t_q;
  logic [F-1:0]          t2_q, t2_d;
  logic signed [F+6:0]   p_q, p_d;
  logic [F-1:0]          t3_q, t3_d;
  logic signed [F+6:0]   inner_q, inner_d;
  logic [F:0]            s_q, s_d;

  logic signed [MW-1:0]  m;
  logic signed [PW-1:0]  prod_p;
  logic [2*F-1:0]        prod_t2;
  logic [2*F-1:0]        prod_t3;
  logic [2*F+3:0]        prod_s;

  always_comb begin
    m       = MW'(signed'({1'b0, frac_i})) * MW'(6) - MW'(15 * (1 << F));
    prod_p  = PW'(signed'({1'b0, frac_i})) * PW'(m);
    p_d     = prod_p[PW-1:F];
    prod_t2 = (2*F)'(frac_i) * (2*F)'(frac_i);
    t2_d    = prod_t2[2*F-1:F];
    prod_t3 = (2*F)'(t2_q) * (2*F)'(t_q);
    t3_d    = prod_t3[2*F-1:F];
    inner_d = p_q + (F+7)'(10 * (1 << F));
    // The inner factor stays between one and ten, so it is never negative.
    prod_s  = (2*F+4)'(t3_q) * (2*F+4)'(inner_q[F+3:0]);
    s_d     = prod_s[2*F:F];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q     <= frac_i;
      t2_q    <= t2_d;
      p_q     <= p_d;
      t3_q    <= t3_d;
      inner_q <= inner_d;
      s_q     <= s_d;
    end
  end

  assign fade_o = s_q;
endmodule

FILE: rtl/gn3_hash.sv
// ----------------------------------------------------------------------------
// gn3_hash
// Three-stage corner hash through the permutation ROM, giving the gradient
// selects of all eight cube corners.
// ----------------------------------------------------------------------------
module gn3_hash (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [gn3_pkg::CELL_BITS-1:0]      ix_i,
  input  logic [gn3_pkg::CELL_BITS-1:0]      iy_i,
  input  logic [gn3_pkg::CELL_BITS-1:0]      iz_i,
  output logic [3:0]                         hash_o [8]
);
  localparam int CB = gn3_pkg::CELL_BITS;

  logic [CB-1:0] a_q, b_q, iz1_q;
  logic [CB-1:0] aa_q, ab_q, ba_q, bb_q;
  logic [3:0]    h_q [8];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= gn3_pkg::PERM_ROM[ix_i] + iy_i;
      b_q   <= gn3_pkg::PERM_ROM[ix_i + CB'(1)] + iy_i;
      iz1_q <= iz_i;
      aa_q  <= gn3_pkg::PERM_ROM[a_q] + iz1_q;
      ab_q  <= gn3_pkg::PERM_ROM[a_q + CB'(1)] + iz1_q;
      ba_q  <= gn3_pkg::PERM_ROM[b_q] + iz1_q;
      bb_q  <= gn3_pkg::PERM_ROM[b_q + CB'(1)] + iz1_q;
      // Corner order: bit 0 is x, bit 1 is y, bit 2 is z.
      h_q[0] <= gn3_pkg::PERM_ROM[aa_q][3:0];
      h_q[1] <= gn3_pkg::PERM_ROM[ba_q][3:0];
      h_q[2] <= gn3_pkg::PERM_ROM[ab_q][3:0];
      h_q[3] <= gn3_pkg::PERM_ROM[bb_q][3:0];
      h_q[4] <= gn3_pkg::PERM_ROM[aa_q + CB'(1)][3:0];
      h_q[5] <= gn3_pkg::PERM_ROM[ba_q + CB'(1)][3:0];
      h_q[6] <= gn3_pkg::PERM_ROM[ab_q + CB'(1)][3:0];
      h_q[7] <= gn3_pkg::PERM_ROM[bb_q + CB'(1)][3:0];
    end
  end

  assign hash_o = h_q;
endmodule

FILE: rtl/gradient_noise_3d.sv
// ----------------------------------------------------------------------------
// gradient_noise_3d
// Improved 3-D gradient noise on fixed-point coordinates, fully pipelined.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                              Handshake
//  in_i      in         coord_x, coord_y, coord_z (s32)      valid/ready
//  out_o     out        noise_value (s19)                    valid/ready
//
//  One point is taken every cycle unless the output stalls; each result
//  leaves through the stages below and is held in the output register.
//  Stages: input register, three fade/hash stages, gradients, then one
//  interpolation stage per axis, the last of which is the output register.
//  The whole pipeline holds while a finished result waits; nothing is lost.
//  Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module gradient_noise_3d (
  input  logic        clk_i,
  input  logic        rst_ni,
  gn3_in_if.sink      in_i,
  gn3_out_if.source   out_o
);
  localparam int F      = gn3_pkg::FRAC_BITS;
  localparam int CB     = gn3_pkg::CELL_BITS;
  localparam int OW     = gn3_pkg::OFS_W;
  localparam int LW     = gn3_pkg::LERP_W;
  localparam int FW     = gn3_pkg::FADE_W;
  localparam int NSTAGE = 8;

  logic              en;
  logic [NSTAGE-1:0] vld_q, vld_d;

  logic [F-1:0]  fx_q, fy_q, fz_q;
  logic [CB-1:0] ix_q, iy_q, iz_q;
  logic [F-1:0]  fxd_q [3];
  logic [F-1:0]  fyd_q [3];
  logic [F-1:0]  fzd_q [3];

  logic [FW-1:0] fu, fv, fw;
  logic [3:0]    hash [8];

  logic signed [LW-1:0] g_q [8];
  logic [FW-1:0]        u5_q, v5_q, w5_q;
  logic signed [LW-1:0] lx_q [4];
  logic [FW-1:0]        v6_q, w6_q;
  logic signed [LW-1:0] ly_q [2];
  logic [FW-1:0]        w7_q;
  logic signed [gn3_pkg::OUT_BITS-1:0] noise_q, noise_d;

  logic signed [OW-1:0] ox0, ox1, oy0, oy1, oz0, oz1;
  logic signed [LW-1:0] r;

  assign en          = !vld_q[NSTAGE-1] || out_o.ready;
  assign in_i.ready  = en;
  assign vld_d       = {vld_q[NSTAGE-2:0], in_i.valid};
  assign out_o.valid = vld_q[NSTAGE-1];
  assign out_o.noise_value = noise_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  gn3_fade u_fade_x (.clk_i(clk_i), .en_i(en), .frac_i(fx_q), .fade_o(fu));
  gn3_fade u_fade_y (.clk_i(clk_i), .en_i(en), .frac_i(fy_q), .fade_o(fv));
  gn3_fade u_fade_z (.clk_i(clk_i), .en_i(en), .frac_i(fz_q), .fade_o(fw));

  gn3_hash u_hash (
    .clk_i  (clk_i),
    .en_i   (en),
    .ix_i   (ix_q),
    .iy_i   (iy_q),
    .iz_i   (iz_q),
    .hash_o (hash)
  );

  always_comb begin
    ox0 = signed'({2'b00, fxd_q[2]});
    oy0 = signed'({2'b00, fyd_q[2]});
    oz0 = signed'({2'b00, fzd_q[2]});
    ox1 = ox0 - OW'(1 << F);
    oy1 = oy0 - OW'(1 << F);
    oz1 = oz0 - OW'(1 << F);

    r = gn3_pkg::lerp(w7_q, ly_q[0], ly_q[1]);
    if (r > LW'((1 << (gn3_pkg::OUT_BITS - 1)) - 1)) begin
      noise_d = gn3_pkg::OUT_BITS'((1 << (gn3_pkg::OUT_BITS - 1)) - 1);
    end else if (r < -LW'(1 << (gn3_pkg::OUT_BITS - 1))) begin
      noise_d = gn3_pkg::OUT_BITS'(-(1 << (gn3_pkg::OUT_BITS - 1)));
    end else begin
      noise_d = r[gn3_pkg::OUT_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // Floor split: the fraction is the low bits, the cell the next eight.
      fx_q <= in_i.coord_x[F-1:0];
      fy_q <= in_i.coord_y[F-1:0];
      fz_q <= in_i.coord_z[F-1:0];
      ix_q <= in_i.coord_x[F+CB-1:F];
      iy_q <= in_i.coord_y[F+CB-1:F];
      iz_q <= in_i.coord_z[F+CB-1:F];

      fxd_q[0] <= fx_q;  fxd_q[1] <= fxd_q[0];  fxd_q[2] <= fxd_q[1];
      fyd_q[0] <= fy_q;  fyd_q[1] <= fyd_q[0];  fyd_q[2] <= fyd_q[1];
      fzd_q[0] <= fz_q;  fzd_q[1] <= fzd_q[0];  fzd_q[2] <= fzd_q[1];

      g_q[0] <= LW'(gn3_pkg::grad_dot(hash[0], ox0, oy0, oz0));
      g_q[1] <= LW'(gn3_pkg::grad_dot(hash[1], ox1, oy0, oz0));
      g_q[2] <= LW'(gn3_pkg::grad_dot(hash[2], ox0, oy1, oz0));
      g_q[3] <= LW'(gn3_pkg::grad_dot(hash[3], ox1, oy1, oz0));
      g_q[4] <= LW'(gn3_pkg::grad_dot(hash[4], ox0, oy0, oz1));
      g_q[5] <= LW'(gn3_pkg::grad_dot(hash[5], ox1, oy0, oz1));
      g_q[6] <= LW'(gn3_pkg::grad_dot(hash[6], ox0, oy1, oz1));
      g_q[7] <= LW'(gn3_pkg::grad_dot(hash[7], ox1, oy1, oz1));
      u5_q <= fu;
      v5_q <= fv;
      w5_q <= fw;

      lx_q[0] <= gn3_pkg::lerp(u5_q, g_q[0], g_q[1]);
      lx_q[1] <= gn3_pkg::lerp(u5_q, g_q[2], g_q[3]);
      lx_q[2] <= gn3_pkg::lerp(u5_q, g_q[4], g_q[5]);
      lx_q[3] <= gn3_pkg::lerp(u5_q, g_q[6], g_q[7]);
      v6_q <= v5_q;
      w6_q <= w5_q;

      ly_q[0] <= gn3_pkg::lerp(v6_q, lx_q[0], lx_q[1]);
      ly_q[1] <= gn3_pkg::lerp(v6_q, lx_q[2], lx_q[3]);
      w7_q <= w6_q;

      noise_q <= noise_d;
    end
  end
endmodule
